### hw/rtl/cfr_pkg.sv
// cfr_pkg: shared types, constants and crc function for the framed receiver
// no dependencies

package cfr_pkg;

  localparam logic [7:0]  StxByte = 8'h02;
  localparam logic [7:0]  EtxByte = 8'h03;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam int unsigned PosW = 9;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_GOOD    = 2'd1,
    ST_LEN_REJ = 2'd2,
    ST_BAD     = 2'd3
  } status_e;

  typedef struct packed {
    logic    frame_ok;
    status_e status;
  } result_t;

  // crc-16 ccitt, msb first, one byte
  function automatic logic [15:0] crc_add_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/cfr_if.sv
// cfr_in_if / cfr_out_if: valid/ready channels for received bytes and results
// no dependencies

interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_out_if;
  logic       valid;
  logic       ready;
  logic       frame_ok;
  logic [1:0] status;

  modport source (output valid, output frame_ok, output status, input ready);
  modport sink   (input valid, input frame_ok, input status, output ready);
endinterface

### hw/rtl/crc_checked_frame_receiver_top.sv
// crc_checked_frame_receiver_top: byte input register, parser, result register, apb config
// depends on cfr_pkg, cfr_if, cfr_parser
// path: byte to input register, parser step into result register when res_adv allows
// throughput: one byte per cycle unless out_if.ready holds off results; crc byte unrolled
// reset: async active low; parser idle, crc 0xffff, max_payload 255, both stages empty

module crc_checked_frame_receiver_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  cfr_in_if.sink           in_if,
  cfr_out_if.source        out_if,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import cfr_pkg::*;

  localparam logic RegMaxPayload = 1'b0;

  logic [7:0] max_payload_q;
  logic       s0_valid_q;
  logic [7:0] s0_byte_q;
  logic       res_valid_q;
  result_t    res_q;
  result_t    step_res;
  logic       res_adv;
  logic       s0_fire;
  logic       in_xfer;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMaxPayload) ? {24'h0, max_payload_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= 8'hFF;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegMaxPayload) begin
      max_payload_q <= pwdata[7:0];
    end
  end

  assign res_adv     = !res_valid_q || out_if.ready;
  assign s0_fire     = s0_valid_q && res_adv;
  assign in_if.ready = !s0_valid_q || res_adv;
  assign in_xfer     = in_if.valid && in_if.ready;

  cfr_parser u_parser (
    .clk_i,
    .rst_ni,
    .step_i        (s0_fire),
    .byte_i        (s0_byte_q),
    .max_payload_i (max_payload_q),
    .result_o      (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s0_valid_q <= 1'b1;
      end else if (s0_fire) begin
        s0_valid_q <= 1'b0;
      end
      if (s0_fire) begin
        res_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s0_byte_q <= in_if.rx_byte;
    end
    if (s0_fire) begin
      res_q <= step_res;
    end
  end

  assign out_if.valid    = res_valid_q;
  assign out_if.frame_ok = res_q.frame_ok;
  assign out_if.status   = res_q.status;

endmodule

### hw/rtl/cfr_parser.sv
// cfr_parser: frame state and per-byte step logic with on-the-fly crc
// depends on cfr_pkg

module cfr_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          max_payload_i,
  output cfr_pkg::result_t    result_o
);
  import cfr_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] total_q, total_d;
  logic [7:0]      len_hi_q, len_hi_d;
  logic [15:0]     crc_q, crc_d;
  logic [15:0]     rx_crc_q, rx_crc_d;
  status_e         status;

  logic [PosW-1:0] pos_inc;
  logic [15:0]     body;
  logic [9:0]      body_lim;
  logic            good;

  assign pos_inc  = pos_q + PosW'(1);
  assign body     = {len_hi_q, byte_i};
  assign body_lim = 10'(max_payload_i) + 10'd2;
  assign good     = (pos_inc == total_q) && (byte_i == EtxByte) && (rx_crc_q == crc_q);

  always_comb begin
    pos_d    = pos_q;
    total_d  = total_q;
    len_hi_d = len_hi_q;
    crc_d    = crc_q;
    rx_crc_d = rx_crc_q;
    status   = ST_NONE;
    if (pos_q == '0) begin
      if (byte_i == StxByte) begin
        pos_d   = PosW'(1);
        total_d = '0;
        crc_d   = CrcInit;
      end
    end else begin
      pos_d = pos_inc;
      priority if (pos_inc == PosW'(2)) begin
        len_hi_d = byte_i;
      end else if (pos_inc == PosW'(3)) begin
        if (body < 16'd2 || body > 16'(body_lim)) begin
          pos_d  = '0;
          status = ST_LEN_REJ;
        end else begin
          total_d = body[PosW-1:0] + PosW'(6);
        end
      end else if (total_q < PosW'(8)) begin
        pos_d = '0;
      end else if (pos_inc >= total_q || pos_inc < PosW'(4)) begin
        status = good ? ST_GOOD : ST_BAD;
        pos_d  = '0;
      end else if (pos_inc <= total_q - PosW'(3)) begin
        crc_d = crc_add_byte(crc_q, byte_i);
      end else if (pos_inc == total_q - PosW'(2)) begin
        rx_crc_d = {byte_i, 8'h00};
      end else begin
        rx_crc_d = {rx_crc_q[15:8], byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      total_q  <= '0;
      len_hi_q <= '0;
      crc_q    <= CrcInit;
      rx_crc_q <= '0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      total_q  <= total_d;
      len_hi_q <= len_hi_d;
      crc_q    <= crc_d;
      rx_crc_q <= rx_crc_d;
    end
  end

  assign result_o.frame_ok = (status == ST_GOOD);
  assign result_o.status   = status;

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && status != ST_NONE |=> pos_q == '0)
    else $error("frame end did not return to idle");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q == '0 || (total_q >= PosW'(8) && total_q <= PosW'(263)))
    else $error("frame total out of range");

  a_hold_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(pos_q) && $stable(crc_q))
    else $error("state moved without a byte");

endmodule

### bench/cfr_bench_pkg.sv
// cfr_bench_pkg: register map and crc step shared by the frame receiver bench
// depends on cfr_pkg

`timescale 1ns / 100ps

package cfr_bench_pkg;

  import cfr_pkg::*;

  localparam logic [2:0] MaxPayloadAddr = 3'd0;

  // crc-16 ccitt-false, one byte folded in bit by bit
  function automatic logic [15:0] crc16_ccitt_step(logic [15:0] crc, logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ data[k];
      r = {r[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

endpackage

### bench/cfr_result_check.sv
// cfr_result_check: watches byte, result and apb traffic, predicts each byte's status
// depends on cfr_pkg, cfr_bench_pkg, cfr_if

`timescale 1ns / 100ps

module cfr_result_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfr_in_if           in_mon,
  cfr_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending_count
);

  import cfr_pkg::*;
  import cfr_bench_pkg::*;

  logic [7:0]  limit_q;
  logic [8:0]  pos_q;
  logic [8:0]  total_q;
  logic [7:0]  len_hi_q;
  logic [15:0] crc_q;
  logic [15:0] rx_crc_q;
  result_t     status_fifo[$];

  function automatic result_t parse_byte(logic [7:0] b);
    result_t     r;
    logic [8:0]  p;
    logic [15:0] body;
    r.status = ST_NONE;
    if (pos_q == '0) begin
      if (b == StxByte) begin
        pos_q = 9'd1;
        total_q = '0;
        crc_q = CrcInit;
      end
    end else begin
      p = pos_q + 9'd1;
      pos_q = p;
      if (p == 9'd2) begin
        len_hi_q = b;
      end else if (p == 9'd3) begin
        body = {len_hi_q, b};
        if (body < 16'd2 || body > 16'd2 + 16'(limit_q)) begin
          pos_q = '0;
          r.status = ST_LEN_REJ;
        end else begin
          total_q = 9'(body + 16'd6);
        end
      end else if (total_q < 9'd8) begin
        pos_q = '0;
      end else if (p >= total_q || p < 9'd4) begin
        r.status = (p == total_q && b == EtxByte && rx_crc_q == crc_q) ? ST_GOOD : ST_BAD;
        pos_q = '0;
      end else if (p <= total_q - 9'd3) begin
        crc_q = crc16_ccitt_step(crc_q, b);
      end else if (p == total_q - 9'd2) begin
        rx_crc_q = {b, 8'h00};
      end else begin
        rx_crc_q = {rx_crc_q[15:8], b};
      end
    end
    r.frame_ok = (r.status == ST_GOOD);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      limit_q = 8'd255;
      pos_q = '0;
      total_q = '0;
      len_hi_q = '0;
      crc_q = CrcInit;
      rx_crc_q = '0;
      status_fifo.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == MaxPayloadAddr) begin
        limit_q = pwdata[7:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        if (status_fifo.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result transfer: frame_ok %0b status %0d",
                     out_mon.frame_ok, out_mon.status);
          end
        end else begin
          want = status_fifo.pop_front();
          if (out_mon.frame_ok !== want.frame_ok || out_mon.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch: expected frame_ok %0b status %0d, got %0b %0d",
                       want.frame_ok, want.status, out_mon.frame_ok, out_mon.status);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        status_fifo.push_back(parse_byte(in_mon.rx_byte));
      end
    end
    pending_count = status_fifo.size();
  end

endmodule

### bench/tb.sv
// tb: byte stream stimulus, apb setup and verdict for crc_checked_frame_receiver_top
// depends on cfr_pkg, cfr_bench_pkg, cfr_if, cfr_result_check and the rtl

`timescale 1ns / 100ps

module tb;

  import cfr_pkg::*;
  import cfr_bench_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int LongHold  = 300;

  typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_ETX, FR_LEN_BAD, FR_CUT} frame_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic        pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  int          fail_count;
  int          pending_count;
  int          src_idle_pct;
  int          sink_stall_pct;
  bit          hold_phase;
  bit          hold_done;
  int          hold_left;
  int          idle_cycles;
  int          frame_bytes;
  logic [7:0]  limit_now;

  cfr_in_if  in_ch ();
  cfr_out_if out_ch ();

  crc_checked_frame_receiver_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfr_result_check u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // result side, with one long hold-off when the phase asks for it
  always @(negedge clk_i) begin
    if (hold_phase && !hold_done) begin
      hold_left = LongHold;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      in_ch.rx_byte = 8'($urandom);
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.rx_byte = b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    frame_bytes++;
  endtask

  task automatic apb_write(input logic [7:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = MaxPayloadAddr;
    pwdata = {24'h0, value};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    limit_now = value;
  endtask

  task automatic start_phase(input logic [7:0] limit, input int src_pct, input int sink_pct,
                             input bit hold);
    in_ch.valid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    hold_phase = hold;
    apb_write(limit);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // lead gives the first two body bytes when lead_fixed is set
  task automatic send_frame(input logic [15:0] body_len, input frame_kind_e kind,
                            input logic [15:0] lead, input bit lead_fixed);
    logic [15:0] crc;
    logic [7:0]  b;
    int          stop_at;
    crc = CrcInit;
    stop_at = (kind == FR_CUT) ? $urandom_range(0, body_len) : body_len;
    send_byte(StxByte);
    send_byte(body_len[15:8]);
    send_byte(body_len[7:0]);
    if (kind == FR_LEN_BAD) return;
    for (int i = 0; i < stop_at; i++) begin
      case ($urandom_range(0, 9))
        0: b = StxByte;
        1: b = EtxByte;
        default: b = 8'($urandom);
      endcase
      if (lead_fixed && i < 2) b = (i == 0) ? lead[15:8] : lead[7:0];
      crc = crc16_ccitt_step(crc, b);
      send_byte(b);
    end
    if (kind == FR_CUT) return;
    if (kind == FR_BAD_CRC) crc ^= 16'($urandom_range(1, 16'hFFFF));
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
    b = 8'($urandom);
    if (b == EtxByte) b = ~b;
    send_byte((kind == FR_BAD_ETX) ? b : EtxByte);
  endtask

  task automatic random_traffic(input int n_bytes);
    int          start;
    int          pick;
    int          top;
    int          n;
    logic [15:0] len;
    start = frame_bytes;
    while (frame_bytes - start < n_bytes) begin
      top = 2 + limit_now;
      len = ($urandom_range(0, 49) == 0) ? 16'(top)
                                         : 16'($urandom_range(2, (top < 12) ? top : 12));
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame(len, FR_GOOD, 16'h0, 1'b0);
      end else if (pick < 70) begin
        send_frame(len, FR_BAD_CRC, 16'h0, 1'b0);
      end else if (pick < 77) begin
        send_frame(len, FR_BAD_ETX, 16'h0, 1'b0);
      end else if (pick < 87) begin
        case ($urandom_range(0, 2))
          0: len = 16'($urandom_range(0, 1));
          1: len = 16'(top + 1);
          default: len = 16'($urandom);
        endcase
        send_frame(len, FR_LEN_BAD, 16'h0, 1'b0);
      end else if (pick < 94) begin
        // line noise between frames, not counted
        n = $urandom_range(1, 3);
        repeat (n) send_byte(8'($urandom));
        frame_bytes -= n;
      end else begin
        send_frame(len, FR_CUT, 16'h0, 1'b0);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_phase = 1'b0;
    frame_bytes = 0;
    limit_now = 8'd255;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero payload limit: a body of two is both the shortest and longest frame
    start_phase(8'd0, 0, 0, 1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(16'd2, FR_GOOD, {StxByte, EtxByte}, 1'b1);
    send_frame(16'd1, FR_LEN_BAD, 16'h0, 1'b0);
    send_frame(16'd3, FR_LEN_BAD, 16'h0, 1'b0);
    send_frame(16'd2, FR_BAD_CRC, 16'hFF00, 1'b1);

    start_phase(8'd255, 0, 0, 1'b0);
    random_traffic(100);
    start_phase(8'd1, 57, 0, 1'b0);
    random_traffic(100);
    start_phase(8'($urandom_range(2, 254)), 0, 57, 1'b1);
    random_traffic(100);
    start_phase(8'd255, 22, 22, 1'b0);
    random_traffic(100);
    start_phase(8'd0, 0, 0, 1'b0);
    random_traffic(100);

    in_ch.valid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
